FILE: rtl/pgpd_pkg.sv
// ----------------------------------------------------------------------------
// pgpd_pkg
// Shared constants, register codes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package pgpd_pkg;

  localparam int ZW        = 24;  // angle, 1/16384 deg
  localparam int EW        = 25;  // angle error
  localparam int VW        = 27;  // heading wrap work width
  localparam int GW        = 32;  // gain * rate product
  localparam int XW        = 41;  // PD numerator
  localparam int PW        = 30;  // gain * rate gain
  localparam int TW        = 48;  // divider remainder
  localparam int QW        = 16;  // quotient bits, top bit flags overflow
  localparam int TABLE_LEN = 24;
  localparam int HALF_TURN = 2949120;
  localparam int FULL_TURN = 5898240;
  localparam int KINV_Q16  = 39797;
  localparam int CMD_MAX   = 32767;

  localparam logic [1:0] REG_HEADING_GAIN    = 2'd0;
  localparam logic [1:0] REG_ROLL_RATE_GAIN  = 2'd1;
  localparam logic [1:0] REG_PITCH_GAIN      = 2'd2;
  localparam logic [1:0] REG_PITCH_RATE_GAIN = 2'd3;

  localparam logic [14:0] HEADING_GAIN_RST    = 15'd1920;
  localparam logic [14:0] ROLL_RATE_GAIN_RST  = 15'd3840;
  localparam logic [14:0] PITCH_GAIN_RST      = 15'd1280;
  localparam logic [14:0] PITCH_RATE_GAIN_RST = 15'd3840;

  function automatic logic signed [ZW-1:0] cordic_atan(input int unsigned idx);
    logic signed [ZW-1:0] a;
    unique case (idx)
      0:       a = ZW'(737280);
      1:       a = ZW'(435242);
      2:       a = ZW'(229970);
      3:       a = ZW'(116736);
      4:       a = ZW'(58595);
      5:       a = ZW'(29326);
      6:       a = ZW'(14667);
      7:       a = ZW'(7334);
      8:       a = ZW'(3667);
      9:       a = ZW'(1833);
      10:      a = ZW'(917);
      11:      a = ZW'(458);
      12:      a = ZW'(229);
      13:      a = ZW'(115);
      14:      a = ZW'(57);
      15:      a = ZW'(29);
      16:      a = ZW'(14);
      17:      a = ZW'(7);
      18:      a = ZW'(4);
      19:      a = ZW'(2);
      20:      a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/pgpd_cordic_cell.sv
// ----------------------------------------------------------------------------
// pgpd_cordic_cell
// One vectoring CORDIC iteration with its output register.
// ----------------------------------------------------------------------------
module pgpd_cordic_cell import pgpd_pkg::*; #(
  parameter int W    = 39,
  parameter int STEP = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] ANG = cordic_atan(STEP);

  logic signed [W-1:0]  xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;

  assign xs = x_i >>> STEP;
  assign ys = y_i >>> STEP;

  always_comb begin
    x_d = x_i;
    y_d = y_i;
    z_d = z_i;
    if (y_i > 0) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ANG;
    end else if (y_i < 0) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

FILE: rtl/pgpd_div_cell.sv
// ----------------------------------------------------------------------------
// pgpd_div_cell
// One restoring division step producing one quotient bit.
// ----------------------------------------------------------------------------
module pgpd_div_cell import pgpd_pkg::*; #(
  parameter int K = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [TW-1:0] r_i,
  input  logic [PW-1:0] p_i,
  input  logic [QW-1:0] q_i,
  input  logic          neg_i,
  output logic [TW-1:0] r_o,
  output logic [PW-1:0] p_o,
  output logic [QW-1:0] q_o,
  output logic          neg_o
);

  logic [TW-1:0] dsh, r_d, r_q;
  logic          bit_d;
  logic [PW-1:0] p_q;
  logic [QW-1:0] q_q;
  logic          neg_q;

  assign dsh   = TW'(p_i) << K;
  assign bit_d = (r_i >= dsh);
  assign r_d   = bit_d ? r_i - dsh : r_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q   <= r_d;
      p_q   <= p_i;
      q_q   <= {q_i[QW-2:0], bit_d};
      neg_q <= neg_i;
    end
  end

  assign r_o   = r_q;
  assign p_o   = p_q;
  assign q_o   = q_q;
  assign neg_o = neg_q;

endmodule

FILE: rtl/pursuit_guidance_pd_command_unit.sv
// ----------------------------------------------------------------------------
// pursuit_guidance_pd_command_unit
// Path from input word to output word: two CORDIC cell rows of min(CORDIC_STEPS,24)
// cells each and a 16-cell divider, plus the range product and PD term registers.
// Throughput: one word per cycle while the one-word skid stage, which decouples the output, is empty.
// Reset clears valid flags and loads the gain registers with their defaults.
// ----------------------------------------------------------------------------
module pursuit_guidance_pd_command_unit import pgpd_pkg::*; #(
  parameter int CORDIC_STEPS  = 16,
  parameter int POSITION_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // north, east, down, own_heading, own_pitch, own_roll_rate, own_pitch_rate
  input  logic [((3*POSITION_BITS+62+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // roll_command, pitch_command
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i
);

  localparam int PB = POSITION_BITS;
  localparam int W  = PB + 15;
  localparam int NS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int MW = W + 17;

  typedef struct packed {
    logic signed [PB-1:0] down;
    logic signed [15:0]   heading;
    logic signed [13:0]   pitch;
    logic signed [15:0]   roll_rate;
    logic signed [15:0]   pitch_rate;
  } side1_t;

  typedef struct packed {
    logic signed [EW-1:0] herr;
    logic signed [13:0]   pitch;
    logic signed [15:0]   roll_rate;
    logic signed [15:0]   pitch_rate;
  } side2_t;

  logic en;
  logic [14:0] gain_q [4];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q[REG_HEADING_GAIN]    <= HEADING_GAIN_RST;
      gain_q[REG_ROLL_RATE_GAIN]  <= ROLL_RATE_GAIN_RST;
      gain_q[REG_PITCH_GAIN]      <= PITCH_GAIN_RST;
      gain_q[REG_PITCH_RATE_GAIN] <= PITCH_RATE_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HEADING_GAIN:    gain_q[REG_HEADING_GAIN]    <= cfg_data_i;
        REG_ROLL_RATE_GAIN:  gain_q[REG_ROLL_RATE_GAIN]  <= cfg_data_i;
        REG_PITCH_GAIN:      gain_q[REG_PITCH_GAIN]      <= cfg_data_i;
        REG_PITCH_RATE_GAIN: gain_q[REG_PITCH_RATE_GAIN] <= cfg_data_i;
      endcase
    end
  end

  // ---------------- bearing CORDIC ----------------
  logic signed [PB-1:0] in_n, in_e;
  logic signed [W-1:0]  n_sh, e_sh;
  logic signed [W-1:0]  c1_x [0:NS];
  logic signed [W-1:0]  c1_y [0:NS];
  logic signed [ZW-1:0] c1_z [0:NS];
  side1_t               sd1  [0:NS];
  logic                 v1   [0:NS];

  assign in_n = s_axis_tdata[PB-1:0];
  assign in_e = s_axis_tdata[2*PB-1:PB];
  assign n_sh = {{3{in_n[PB-1]}}, in_n, 12'b0};
  assign e_sh = {{3{in_e[PB-1]}}, in_e, 12'b0};

  always_comb begin
    c1_x[0] = n_sh;
    c1_y[0] = e_sh;
    c1_z[0] = '0;
    if (n_sh < 0) begin
      c1_z[0] = (e_sh >= 0) ? ZW'(HALF_TURN) : -ZW'(HALF_TURN);
      c1_x[0] = -n_sh;
      c1_y[0] = -e_sh;
    end
  end

  assign sd1[0].down       = s_axis_tdata[3*PB-1:2*PB];
  assign sd1[0].heading    = s_axis_tdata[3*PB+15:3*PB];
  assign sd1[0].pitch      = s_axis_tdata[3*PB+29:3*PB+16];
  assign sd1[0].roll_rate  = s_axis_tdata[3*PB+45:3*PB+30];
  assign sd1[0].pitch_rate = s_axis_tdata[3*PB+61:3*PB+46];
  assign v1[0]             = s_axis_tvalid & en;

  for (genvar i = 0; i < NS; i++) begin : g_c1
    pgpd_cordic_cell #(.W(W), .STEP(i)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (c1_x[i]),
      .y_i   (c1_y[i]),
      .z_i   (c1_z[i]),
      .x_o   (c1_x[i+1]),
      .y_o   (c1_y[i+1]),
      .z_o   (c1_z[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) sd1[i+1] <= sd1[i];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v1[i+1] <= 1'b0;
      else if (en) v1[i+1] <= v1[i];
    end
  end

  // ---------------- range product, heading wrap ----------------
  logic [VW-1:0]        hv0, hv1, hv2, hv3;
  logic signed [EW-1:0] herr_d;
  logic signed [MW-1:0] mprod_q;
  side2_t               sdb_q;
  logic signed [PB-1:0] down_b_q;
  logic                 vb_q;

  always_comb begin
    hv0 = VW'($signed({{(VW-ZW){c1_z[NS][ZW-1]}}, c1_z[NS]})
        - $signed({{(VW-24){sd1[NS].heading[15]}}, sd1[NS].heading, 8'b0})
        + VW'(HALF_TURN + 3*FULL_TURN));
    hv1 = (hv0 >= VW'(4*FULL_TURN)) ? hv0 - VW'(4*FULL_TURN) : hv0;
    hv2 = (hv1 >= VW'(2*FULL_TURN)) ? hv1 - VW'(2*FULL_TURN) : hv1;
    hv3 = (hv2 >= VW'(FULL_TURN))   ? hv2 - VW'(FULL_TURN)   : hv2;
    herr_d = $signed(EW'(hv3) - EW'(HALF_TURN));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mprod_q          <= c1_x[NS] * $signed(17'(KINV_Q16));
      sdb_q.herr       <= herr_d;
      sdb_q.pitch      <= sd1[NS].pitch;
      sdb_q.roll_rate  <= sd1[NS].roll_rate;
      sdb_q.pitch_rate <= sd1[NS].pitch_rate;
      down_b_q         <= sd1[NS].down;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en) vb_q <= v1[NS];
  end

  // ---------------- elevation CORDIC ----------------
  logic signed [MW-1:0] mround;
  logic signed [W-1:0]  d_sh;
  logic signed [W-1:0]  c2_x [0:NS];
  logic signed [W-1:0]  c2_y [0:NS];
  logic signed [ZW-1:0] c2_z [0:NS];
  side2_t               sd2  [0:NS];
  logic                 v2   [0:NS];
  logic signed [W-1:0]  c2x0_q, c2y0_q;
  side2_t               sd2_0_q;
  logic                 v2_0_q;

  assign mround = mprod_q + MW'(32768);
  assign d_sh   = {{3{down_b_q[PB-1]}}, down_b_q, 12'b0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2x0_q  <= mround[W+15:16];
      c2y0_q  <= -d_sh;
      sd2_0_q <= sdb_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_0_q <= 1'b0;
    else if (en) v2_0_q <= vb_q;
  end

  assign c2_x[0] = c2x0_q;
  assign c2_y[0] = c2y0_q;
  assign c2_z[0] = '0;
  assign sd2[0]  = sd2_0_q;
  assign v2[0]   = v2_0_q;

  for (genvar i = 0; i < NS; i++) begin : g_c2
    pgpd_cordic_cell #(.W(W), .STEP(i)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (c2_x[i]),
      .y_i   (c2_y[i]),
      .z_i   (c2_z[i]),
      .x_o   (c2_x[i+1]),
      .y_o   (c2_y[i+1]),
      .z_o   (c2_z[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) sd2[i+1] <= sd2[i];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v2[i+1] <= 1'b0;
      else if (en) v2[i+1] <= v2[i];
    end
  end

  // ---------------- PD terms and divider, roll = 0, pitch = 1 ----------------
  logic signed [EW-1:0] err_s  [2];
  logic signed [15:0]   rate_s [2];
  logic [14:0]          g_s    [2];
  logic [14:0]          rg_s   [2];
  logic signed [XW-1:0] er_q   [2];
  logic signed [GW-1:0] gr_q   [2];
  logic [PW-1:0]        pd_q   [2];
  logic signed [XW-1:0] x_q    [2];
  logic [PW-1:0]        pe_q   [2];
  logic [TW-1:0]        dr     [2][0:QW];
  logic [PW-1:0]        dp     [2][0:QW];
  logic [QW-1:0]        dq     [2][0:QW];
  logic                 dn     [2][0:QW];
  logic                 vd     [0:QW];
  logic                 vd_q, ve_q;
  logic signed [15:0]   cmd    [2];

  assign err_s[0]  = sd2[NS].herr;
  assign err_s[1]  = $signed({{(EW-ZW){c2_z[NS][ZW-1]}}, c2_z[NS]})
                   - $signed({{3{sd2[NS].pitch[13]}}, sd2[NS].pitch, 8'b0});
  assign rate_s[0] = sd2[NS].roll_rate;
  assign rate_s[1] = sd2[NS].pitch_rate;
  assign g_s[0]    = (gain_q[REG_HEADING_GAIN] == '0) ? 15'd1 : gain_q[REG_HEADING_GAIN];
  assign rg_s[0]   = (gain_q[REG_ROLL_RATE_GAIN] == '0) ? 15'd1
                                                        : gain_q[REG_ROLL_RATE_GAIN];
  assign g_s[1]    = (gain_q[REG_PITCH_GAIN] == '0) ? 15'd1 : gain_q[REG_PITCH_GAIN];
  assign rg_s[1]   = (gain_q[REG_PITCH_RATE_GAIN] == '0) ? 15'd1
                                                         : gain_q[REG_PITCH_RATE_GAIN];

  for (genvar c = 0; c < 2; c++) begin : g_ch
    logic signed [XW-1:0] gsh;
    logic [XW-1:0]        absx;
    logic [TW-1:0]        r0_q;
    logic [PW-1:0]        p0_q;
    logic                 n0_q;
    logic signed [15:0]   mag;

    assign gsh  = {{(XW-GW-8){gr_q[c][GW-1]}}, gr_q[c], 8'b0};
    assign absx = x_q[c][XW-1] ? XW'(-x_q[c]) : XW'(x_q[c]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        er_q[c] <= err_s[c] * $signed({1'b0, rg_s[c]});
        gr_q[c] <= $signed({1'b0, g_s[c]}) * rate_s[c];
        pd_q[c] <= g_s[c] * rg_s[c];
        x_q[c]  <= er_q[c] - gsh;
        pe_q[c] <= pd_q[c];
        r0_q    <= TW'({absx[XW-2:0], 7'b0}) + TW'(pe_q[c] >> 1);
        p0_q    <= pe_q[c];
        n0_q    <= x_q[c][XW-1];
      end
    end

    assign dr[c][0] = r0_q;
    assign dp[c][0] = p0_q;
    assign dq[c][0] = '0;
    assign dn[c][0] = n0_q;

    for (genvar j = 0; j < QW; j++) begin : g_div
      pgpd_div_cell #(.K(QW-1-j)) u_div (
        .clk_i (clk_i),
        .en_i  (en),
        .r_i   (dr[c][j]),
        .p_i   (dp[c][j]),
        .q_i   (dq[c][j]),
        .neg_i (dn[c][j]),
        .r_o   (dr[c][j+1]),
        .p_o   (dp[c][j+1]),
        .q_o   (dq[c][j+1]),
        .neg_o (dn[c][j+1])
      );
    end

    assign mag    = dq[c][QW][QW-1] ? 16'(CMD_MAX) : {1'b0, dq[c][QW][QW-2:0]};
    assign cmd[c] = dn[c][QW] ? -mag : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q  <= 1'b0;
      ve_q  <= 1'b0;
      vd[0] <= 1'b0;
    end else if (en) begin
      vd_q  <= v2[NS];
      ve_q  <= vd_q;
      vd[0] <= ve_q;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_vd
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vd[j+1] <= 1'b0;
      else if (en) vd[j+1] <= vd[j];
    end
  end

  // ---------------- output register and skid ----------------
  logic        out_v_q, skid_v_q, take, out_free;
  logic [31:0] out_q, skid_q, res;

  assign res      = {cmd[1], cmd[0]};
  assign en       = ~skid_v_q;
  assign take     = vd[QW] & en;
  assign out_free = ~out_v_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= take;
      end
    end else if (take) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (take) begin
      skid_q <= res;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid word without output word");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready && take) |=> skid_v_q)
    else $error("result lost while output stalled");

  a_cmd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] != 16'h8000 && m_axis_tdata[31:16] != 16'h8000))
    else $error("command outside saturation range");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pursuit_guidance_pd_command_unit. Guidance words go
// in on the stream input and command words come back. Each output word is
// checked against a bit-exact predictor of the CORDIC bearing and elevation
// path and the PD command math. The bench runs under several gain settings
// with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module testbench;
  import pgpd_pkg::*;

  localparam int STEPS     = 16;
  localparam int DW        = 136;
  localparam int WDOG_MAX  = 5000;
  localparam int DRAIN_CYC = 120;

  typedef struct {
    logic signed [23:0] north;
    logic signed [23:0] east;
    logic signed [23:0] down;
    logic signed [15:0] heading;
    logic signed [13:0] pitch;
    logic signed [15:0] roll_rate;
    logic signed [15:0] pitch_rate;
  } guide_t;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
  } cmd_t;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [DW-1:0] s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [31:0]   m_axis_tdata;
  logic          cfg_we_i;
  logic [1:0]    cfg_idx_i;
  logic [14:0]   cfg_data_i;

  cmd_t        cmd_queue[$];
  logic [14:0] gain_hdg, gain_roll_rate, gain_pitch, gain_pitch_rate;
  int          n_errors, n_words_in, n_words_out, idle_cycles;
  int          src_idle_pct, snk_stall_pct;
  bit          snk_hold;

  longint atan_lut[24] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                           3667, 1833, 917, 458, 229, 115, 57, 29,
                           14, 7, 4, 2, 1, 0, 0, 0};

  pursuit_guidance_pd_command_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic longint cordic_angle(longint y, longint x, output longint mag);
    longint z, xs, ys;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_lut[i];
      end else if (y < 0) begin
        x -= ys; y += xs; z -= atan_lut[i];
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic logic signed [15:0] stick_cmd(longint err, longint rate,
                                                   logic [14:0] g, logic [14:0] rg);
    longint gg, rr, num, den, q;
    gg = (g == 0) ? 1 : g;
    rr = (rg == 0) ? 1 : rg;
    num = 32768 * (err * rr - 256 * gg * rate);
    den = 256 * gg * rr;
    q = (num >= 0) ? (num + den / 2) / den : -((-num + den / 2) / den);
    if (q > CMD_MAX) q = CMD_MAX;
    if (q < -CMD_MAX) q = -CMD_MAX;
    return 16'(q);
  endfunction

  function automatic cmd_t guidance_cmd(guide_t g);
    longint n, e, d, mag, dummy, bearing, herr, range, elev, perr;
    cmd_t c;
    n = longint'(g.north) * 4096;
    e = longint'(g.east) * 4096;
    d = longint'(g.down) * 4096;
    bearing = cordic_angle(e, n, mag);
    herr = (bearing - longint'(g.heading) * 256 + HALF_TURN) % FULL_TURN;
    if (herr < 0) herr += FULL_TURN;
    herr -= HALF_TURN;
    range = (mag * KINV_Q16 + 32768) >>> 16;
    elev = cordic_angle(-d, range, dummy);
    perr = elev - longint'(g.pitch) * 256;
    c.roll  = stick_cmd(herr, g.roll_rate, gain_hdg, gain_roll_rate);
    c.pitch = stick_cmd(perr, g.pitch_rate, gain_pitch, gain_pitch_rate);
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (word %0d)", what, got, want, n_words_out);
    n_errors++;
  endtask

  task automatic write_gain(logic [1:0] idx, logic [14:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    case (idx)
      REG_HEADING_GAIN:    gain_hdg = val;
      REG_ROLL_RATE_GAIN:  gain_roll_rate = val;
      REG_PITCH_GAIN:      gain_pitch = val;
      REG_PITCH_RATE_GAIN: gain_pitch_rate = val;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_gains(logic [14:0] h, logic [14:0] rr, logic [14:0] p, logic [14:0] pr);
    write_gain(REG_HEADING_GAIN, h);
    write_gain(REG_ROLL_RATE_GAIN, rr);
    write_gain(REG_PITCH_GAIN, p);
    write_gain(REG_PITCH_RATE_GAIN, pr);
  endtask

  task automatic send_word(guide_t g);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {2'b0, g.pitch_rate, g.roll_rate, g.pitch, g.heading,
                     g.down, g.east, g.north};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    cmd_queue.push_back(guidance_cmd(g));
    n_words_in++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    while (cmd_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  function automatic guide_t rand_guide();
    guide_t g;
    g.north = 24'($urandom);
    g.east  = 24'($urandom);
    g.down  = 24'($urandom);
    if ($urandom_range(2) == 0) begin
      g.north = $signed(g.north) >>> $urandom_range(23);
      g.east  = $signed(g.east) >>> $urandom_range(23);
      g.down  = $signed(g.down) >>> $urandom_range(23);
    end
    g.heading    = 16'($urandom);
    g.pitch      = 14'($urandom);
    g.roll_rate  = 16'($urandom);
    g.pitch_rate = 16'($urandom);
    if ($urandom_range(1) == 0) begin
      g.heading    = 16'($signed($urandom_range(46080)) - 23040);
      g.pitch      = 14'($signed($urandom_range(11520)) - 5760);
      g.roll_rate  = $signed(g.roll_rate) >>> 4;
      g.pitch_rate = $signed(g.pitch_rate) >>> 4;
    end
    return g;
  endfunction

  function automatic guide_t mk(int n, int e, int d, int h, int p, int rr, int pr);
    guide_t g;
    g.north = 24'(n); g.east = 24'(e); g.down = 24'(d); g.heading = 16'(h);
    g.pitch = 14'(p); g.roll_rate = 16'(rr); g.pitch_rate = 16'(pr);
    return g;
  endfunction

  task automatic test_directed();
    src_idle_pct = 0; snk_stall_pct = 0;
    send_word(mk(0, 0, 0, 0, 0, 0, 0));
    send_word(mk(-1000, 0, 0, 0, 0, 0, 0));
    send_word(mk(0, 0, 0, -11520, 0, 0, 0));
    send_word(mk(-500, 300, 100, 11520, 0, 0, 0));
    send_word(mk(-500, -300, -100, -11520, 0, 0, 0));
    send_word(mk(8388607, 8388607, 8388607, 32767, 8191, 32767, 32767));
    send_word(mk(-8388608, -8388608, -8388608, -32768, -8192, -32768, -32768));
    send_word(mk(-8388608, 8388607, -8388608, 23040, 5760, 0, 0));
    send_word(mk(8388607, -8388608, 8388607, -23040, -5760, 0, 0));
    send_word(mk(1, 0, 0, 0, 0, 32767, -32768));
    send_word(mk(0, 1, -1, 0, 0, -32768, 32767));
    send_word(mk(1000, 1000, -1000, 2880, 2880, 100, -100));
    send_word(mk(0, -1, 1, 0, 0, 0, 0));
    send_word(mk(-1, -1, 0, 0, 0, 0, 0));
    drain();
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct);
    src_idle_pct = idle_pct; snk_stall_pct = stall_pct;
    repeat (n) send_word(rand_guide());
    drain();
  endtask

  task automatic test_gain_extremes();
    set_gains(15'd1, 15'd1, 15'd1, 15'd1);
    test_random(20, 0, 0);
    set_gains(15'd23040, 15'd32767, 15'd23040, 15'd32767);
    test_random(20, 30, 30);
    set_gains(15'd0, 15'd0, 15'd0, 15'd0);
    test_random(15, 0, 57);
    set_gains(15'd32767, 15'd7, 15'd64, 15'd32767);
    test_random(15, 57, 0);
    set_gains(15'($urandom_range(1, 23040)), 15'($urandom_range(1, 32767)),
              15'($urandom_range(1, 23040)), 15'($urandom_range(1, 32767)));
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0; snk_stall_pct = 0;
    fork
      begin
        snk_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        snk_hold = 1'b0;
      end
    join_none
    repeat (80) send_word(rand_guide());
    drain();
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= !snk_hold && ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    cmd_t want;
    if (rst_ni) begin
      idle_cycles <= ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                     ? 0 : idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (cmd_queue.size() == 0) begin
          report_mismatch("unexpected word", int'(m_axis_tdata), 0);
        end else begin
          want = cmd_queue.pop_front();
          if ($signed(m_axis_tdata[15:0]) !== want.roll)
            report_mismatch("roll_command", $signed(m_axis_tdata[15:0]), want.roll);
          if ($signed(m_axis_tdata[31:16]) !== want.pitch)
            report_mismatch("pitch_command", $signed(m_axis_tdata[31:16]), want.pitch);
        end
        n_words_out++;
      end
      if (idle_cycles >= WDOG_MAX) begin
        $display("watchdog: no progress for %0d cycles", WDOG_MAX);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    snk_hold = 1'b0;
    n_errors = 0; n_words_in = 0; n_words_out = 0; idle_cycles = 0;
    src_idle_pct = 0; snk_stall_pct = 0;
    gain_hdg = HEADING_GAIN_RST;
    gain_roll_rate = ROLL_RATE_GAIN_RST;
    gain_pitch = PITCH_GAIN_RST;
    gain_pitch_rate = PITCH_RATE_GAIN_RST;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(60, 0, 0);
    test_gain_extremes();
    test_random(80, 57, 0);
    test_random(80, 0, 57);
    test_random(80, 30, 30);
    test_backpressure();

    $display("%0d words in, %0d words out; directed corners, gain extremes incl. zero,",
             n_words_in, n_words_out);
    $display("random gaps and stalls, long sink hold-off");
    if (n_errors == 0 && cmd_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d errors, %0d words missing", n_errors, cmd_queue.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/pgpd_pkg.sv
rtl/pgpd_cordic_cell.sv
rtl/pgpd_div_cell.sv
rtl/pursuit_guidance_pd_command_unit.sv
test/testbench.sv
